// ===== rtl/pcm_voice_mixer_macros.svh =====
// Assertion helpers used by the bound checker file.
`ifndef PCM_VOICE_MIXER_MACROS_SVH
`define PCM_VOICE_MIXER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PMX_ASSERT(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) expr) \
        else $error(msg);

// Check a property on every clock edge, reset included.
`define PMX_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) expr) \
        else $error(msg);

`endif

// ===== rtl/pmx_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pmx_pkg;

    localparam int VOICES           = 4;
    localparam int CLIPS            = 16;
    localparam int SAMPLE_ADDR_BITS = 16;

    localparam int SAMPLE_W  = 16;
    localparam int LEN_W     = 17;
    localparam int VOL_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;
    localparam int MEM_DEPTH = 1 << SAMPLE_ADDR_BITS;

    localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int VCNT_W = $clog2(VOICES + 1);
    localparam int CIDX_W = (CLIPS > 1) ? $clog2(CLIPS) : 1;
    localparam int ACC_W  = SAMPLE_W + $clog2(VOICES);
    localparam int PROD_W = ACC_W + VOL_W + 1;
    localparam int MIX_SHIFT = 8;

    localparam int VOLUME_RESET = 22;
    localparam int SAMPLE_MAX   = 32767;
    localparam int SAMPLE_MIN   = -32768;

    localparam logic signed [PROD_W-1:0] PROD_MAX = PROD_W'(SAMPLE_MAX);
    localparam logic signed [PROD_W-1:0] PROD_MIN = PROD_W'(SAMPLE_MIN);

    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED = CFG_IDX_W'(1);

    typedef logic [SAMPLE_ADDR_BITS-1:0] t_saddr;
    typedef logic [LEN_W-1:0]            t_len;
    typedef logic [VIDX_W-1:0]           t_vidx;
    typedef logic [VCNT_W-1:0]           t_vcnt;
    typedef logic [CIDX_W-1:0]           t_cidx;
    typedef logic signed [ACC_W-1:0]     t_acc;

    typedef enum logic [1:0] {
        OP_LOAD_SAMPLE = 2'd0,
        OP_LOAD_CLIP   = 2'd1,
        OP_PLAY        = 2'd2,
        OP_TICK        = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PICK,
        S_MIX,
        S_DRAIN,
        S_SEND
    } t_state;

    typedef struct packed {
        logic valid;
        t_acc acc;
    } t_scale_req;

endpackage

`default_nettype wire

// ===== rtl/pmx_scaler.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pmx_scaler import pmx_pkg::*; (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_scale_req                 i_req,
    input  wire logic [VOL_W-1:0]           i_volume,
    output logic                            o_busy,
    output logic                            o_strobe,
    output logic signed [SAMPLE_W-1:0]      o_sample
);

    logic                       r_prod_valid;
    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out;

    logic signed [PROD_W-1:0]   w_prod;
    logic signed [PROD_W-1:0]   w_shift;
    logic signed [SAMPLE_W-1:0] w_sat;

    assign w_prod  = PROD_W'(i_req.acc) * $signed({1'b0, i_volume});
    // Arithmetic shift floors toward minus infinity.
    assign w_shift = r_prod >>> MIX_SHIFT;

    always_comb begin
        if (w_shift > PROD_MAX) begin
            w_sat = SAMPLE_W'(PROD_MAX);
        end else if (w_shift < PROD_MIN) begin
            w_sat = SAMPLE_W'(PROD_MIN);
        end else begin
            w_sat = w_shift[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_prod_valid <= i_req.valid;
            r_out_valid  <= r_prod_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid) begin
            r_prod <= w_prod;
        end
        if (r_prod_valid) begin
            r_out <= w_sat;
        end
    end

    assign o_busy   = r_prod_valid || r_out_valid;
    assign o_strobe = r_out_valid;
    assign o_sample = r_out;

endmodule

`default_nettype wire

// ===== rtl/pcm_voice_mixer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Multi-voice PCM mixer, one mono sample per enabled tick command.
// Command channel: an item is taken on a rising edge with start high and
// busy low. Opcodes load a sample word, load a clip descriptor, play a clip
// or tick the mixer.
// Loads finish in the accept cycle; busy stays low and the next command can
// follow at once. A play walks the voices one per cycle to pick a free or
// the most advanced voice and stays busy until the walk ends. A tick walks
// the voices one per cycle through the single sample memory read port and
// the shared accumulator, adds the last fetch, then scales in a two-stage
// multiply and saturate unit that registers the product, then the result.
// Busy stays high through the strobe cycle, so the next command after a tick
// is taken only after its strobe. A disabled tick or play is taken and does nothing.
// Result channel: o_strobe marks o_mixed_sample for one cycle; the receiver
// cannot stall it.
// Configuration channel: o_cfg_ready is always high; write only while idle.
// Synchronous reset clears voices and clip table, sets volume and disables
// output. Sample memory is not cleared and holds no reset value.

module pcm_voice_mixer import pmx_pkg::*; (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [1:0]                 i_opcode,
    input  wire logic [15:0]                i_address,
    input  wire logic signed [15:0]         i_sample_data,
    input  wire logic [3:0]                 i_clip_index,
    input  wire logic [16:0]                i_clip_length,
    output logic                            o_strobe,
    output logic signed [15:0]              o_mixed_sample,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0]       i_cfg_data
);

    logic [SAMPLE_W-1:0]        r_mem [MEM_DEPTH];
    logic signed [SAMPLE_W-1:0] r_rdata;

    t_state            r_state, n_state;
    t_vcnt             r_vidx, n_vidx;
    logic              r_pend, n_pend;
    logic              r_found, n_found;
    t_acc              r_acc, n_acc;
    t_len              r_best, n_best;
    t_vidx             r_pick, n_pick;
    t_saddr            r_pbase, n_pbase;
    t_len              r_plen, n_plen;
    t_saddr            r_vbase [VOICES];
    t_saddr            n_vbase [VOICES];
    t_len              r_vlen [VOICES];
    t_len              n_vlen [VOICES];
    t_len              r_vpos [VOICES];
    t_len              n_vpos [VOICES];
    t_saddr            r_clip_start [CLIPS];
    t_saddr            n_clip_start [CLIPS];
    t_len              r_clip_len [CLIPS];
    t_len              n_clip_len [CLIPS];
    logic [VOL_W-1:0]  r_volume, n_volume;
    logic              r_enabled, n_enabled;

    logic       w_accept;
    logic       w_mem_we;
    t_saddr     w_wr_addr;
    t_saddr     w_rd_addr;
    t_vidx      w_vi;
    logic       w_last;
    t_len       w_pos_inc;
    t_cidx      w_cidx;
    logic       w_clip_ok;
    t_scale_req w_req;
    logic       w_scale_busy;

    assign w_accept  = start && !busy;
    assign w_vi      = r_vidx[VIDX_W-1:0];
    assign w_last    = (r_vidx == t_vcnt'(VOICES - 1));
    assign w_cidx    = t_cidx'(i_clip_index);
    assign w_clip_ok = (32'(i_clip_index) < CLIPS);
    assign w_wr_addr = t_saddr'(i_address);
    assign w_rd_addr = r_vbase[w_vi] + t_saddr'(r_vpos[w_vi]);
    assign w_pos_inc = r_vpos[w_vi] + t_len'(1);

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_wr_addr] <= i_sample_data;
        end
        r_rdata <= r_mem[w_rd_addr];
    end

    always_comb begin
        n_state      = r_state;
        n_vidx       = r_vidx;
        n_pend       = 1'b0;
        n_found      = r_found;
        n_acc        = r_acc;
        n_best       = r_best;
        n_pick       = r_pick;
        n_pbase      = r_pbase;
        n_plen       = r_plen;
        n_vbase      = r_vbase;
        n_vlen       = r_vlen;
        n_vpos       = r_vpos;
        n_clip_start = r_clip_start;
        n_clip_len   = r_clip_len;
        n_volume     = r_volume;
        n_enabled    = r_enabled;
        w_mem_we     = 1'b0;
        w_req.valid  = 1'b0;
        w_req.acc    = r_acc;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_VOLUME:  n_volume  = i_cfg_data[VOL_W-1:0];
                CFG_ENABLED: n_enabled = i_cfg_data[0];
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (t_opcode'(i_opcode))
                        OP_LOAD_SAMPLE: w_mem_we = 1'b1;
                        OP_LOAD_CLIP: begin
                            if (w_clip_ok) begin
                                n_clip_start[w_cidx] = w_wr_addr;
                                n_clip_len[w_cidx]   = i_clip_length;
                            end
                        end
                        OP_PLAY: begin
                            if (r_enabled && w_clip_ok) begin
                                n_pbase = r_clip_start[w_cidx];
                                n_plen  = r_clip_len[w_cidx];
                                n_vidx  = '0;
                                n_best  = '0;
                                n_pick  = '0;
                                n_found = 1'b0;
                                n_state = S_PICK;
                            end
                        end
                        OP_TICK: begin
                            if (r_enabled) begin
                                n_vidx  = '0;
                                n_acc   = '0;
                                n_state = S_MIX;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_PICK: begin
                // First free voice wins; otherwise keep the furthest along.
                if (!r_found) begin
                    if (r_vlen[w_vi] == '0) begin
                        n_pick  = w_vi;
                        n_found = 1'b1;
                    end else if (r_vpos[w_vi] > r_best) begin
                        n_best = r_vpos[w_vi];
                        n_pick = w_vi;
                    end
                end
                if (w_last) begin
                    n_vbase[n_pick] = r_pbase;
                    n_vlen[n_pick]  = r_plen;
                    n_vpos[n_pick]  = '0;
                    n_state         = S_IDLE;
                end else begin
                    n_vidx = r_vidx + t_vcnt'(1);
                end
            end
            S_MIX: begin
                // Add the word fetched for the previous voice, fetch this one.
                if (r_pend) begin
                    n_acc = r_acc + ACC_W'(r_rdata);
                end
                if (r_vlen[w_vi] != '0) begin
                    n_pend       = 1'b1;
                    n_vpos[w_vi] = w_pos_inc;
                    if (w_pos_inc >= r_vlen[w_vi]) begin
                        n_vlen[w_vi] = '0;
                    end
                end
                if (w_last) begin
                    n_state = S_DRAIN;
                end else begin
                    n_vidx = r_vidx + t_vcnt'(1);
                end
            end
            S_DRAIN: begin
                if (r_pend) begin
                    n_acc = r_acc + ACC_W'(r_rdata);
                end
                n_state = S_SEND;
            end
            S_SEND: begin
                w_req.valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_vidx       <= '0;
            r_pend       <= 1'b0;
            r_found      <= 1'b0;
            r_vbase      <= '{default: '0};
            r_vlen       <= '{default: '0};
            r_vpos       <= '{default: '0};
            r_clip_start <= '{default: '0};
            r_clip_len   <= '{default: '0};
            r_volume     <= VOL_W'(VOLUME_RESET);
            r_enabled    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_vidx       <= n_vidx;
            r_pend       <= n_pend;
            r_found      <= n_found;
            r_vbase      <= n_vbase;
            r_vlen       <= n_vlen;
            r_vpos       <= n_vpos;
            r_clip_start <= n_clip_start;
            r_clip_len   <= n_clip_len;
            r_volume     <= n_volume;
            r_enabled    <= n_enabled;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_best  <= n_best;
        r_pick  <= n_pick;
        r_pbase <= n_pbase;
        r_plen  <= n_plen;
    end

    pmx_scaler u_scaler (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_req),
        .i_volume (r_volume),
        .o_busy   (w_scale_busy),
        .o_strobe (o_strobe),
        .o_sample (o_mixed_sample)
    );

    assign busy        = (r_state != S_IDLE) || w_scale_busy;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

// ===== rtl/pmx_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "pcm_voice_mixer_macros.svh"

module pmx_checker import pmx_pkg::*; (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 start,
    input wire logic                 busy,
    input wire logic [1:0]           i_opcode,
    input wire logic [15:0]          i_address,
    input wire logic signed [15:0]   i_sample_data,
    input wire logic [3:0]           i_clip_index,
    input wire logic [16:0]          i_clip_length,
    input wire logic                 o_strobe,
    input wire logic signed [15:0]   o_mixed_sample,
    input wire logic                 i_cfg_valid,
    input wire logic                 o_cfg_ready,
    input wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input wire logic [CFG_DAT_W-1:0] i_cfg_data
);

    logic w_load_take;

    assign w_load_take = start && !busy
                         && (i_opcode == OP_LOAD_SAMPLE || i_opcode == OP_LOAD_CLIP);

    // Reset leaves the block idle with no result pending.
    `PMX_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (!busy && !o_strobe), "active after reset")

    // A result transfer only comes out of a tick still in flight.
    `PMX_ASSERT(a_strobe_busy, o_strobe |-> busy, "result strobe while idle")

    // Each tick gives at most one result, so strobes never touch.
    `PMX_ASSERT(a_strobe_single, o_strobe |=> !o_strobe, "back-to-back result strobes")

    // Loads complete in the accept cycle.
    `PMX_ASSERT(a_load_quick, w_load_take |=> !busy, "busy after a load")

endmodule

bind pcm_voice_mixer pmx_checker u_pmx_checker (.*);

`default_nettype wire

// ===== verif/pmx_mix_checker.sv =====
`timescale 1ns / 1ps

// Watches the command, config and result channels of the mixer, keeps its own
// copy of the clip table and voices, and scores every mixed sample in order.
module pmx_mix_checker import pmx_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic                   i_busy,
    input  wire logic [1:0]             i_opcode,
    input  wire logic [15:0]            i_address,
    input  wire logic signed [15:0]     i_sample_data,
    input  wire logic [3:0]             i_clip_index,
    input  wire logic [16:0]            i_clip_length,
    input  wire logic                   i_strobe,
    input  wire logic signed [15:0]     i_mixed_sample,
    input  wire logic                   i_cfg_valid,
    input  wire logic                   i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0]   i_cfg_data,
    output int                          o_err_count,
    output int                          o_waiting
);

    logic signed [15:0] pcm_mem [MEM_DEPTH];
    t_saddr             clip_start [CLIPS];
    t_len               clip_len [CLIPS];
    t_saddr             voice_base [VOICES];
    t_len               voice_len [VOICES];
    t_len               voice_pos [VOICES];
    logic [VOL_W-1:0]   mix_volume;
    logic               mix_on;
    logic signed [15:0] mix_due [$];
    logic signed [15:0] want;
    int                 mismatches = 0;

    // Sum the active voices, advance them, then scale by volume and clamp.
    function automatic logic signed [15:0] mix_voices();
        longint sum;
        longint scaled;
        t_saddr rd_addr;
        sum = 0;
        for (int v = 0; v < VOICES; v++) begin
            if (voice_len[v] != '0) begin
                rd_addr = voice_base[v] + t_saddr'(voice_pos[v]);
                sum += longint'(pcm_mem[rd_addr]);
                voice_pos[v] = voice_pos[v] + t_len'(1);
                if (voice_pos[v] >= voice_len[v]) begin
                    voice_len[v] = '0;
                end
            end
        end
        // floor division by 256
        scaled = (sum * longint'({1'b0, mix_volume})) >>> MIX_SHIFT;
        if (scaled > longint'(SAMPLE_MAX)) begin
            scaled = longint'(SAMPLE_MAX);
        end
        if (scaled < longint'(SAMPLE_MIN)) begin
            scaled = longint'(SAMPLE_MIN);
        end
        return scaled[15:0];
    endfunction

    // Take the first free voice, else the one furthest along (lowest on a tie).
    function automatic void start_voice(logic [3:0] clip);
        int   pick;
        t_len best;
        bit   found;
        pick  = 0;
        best  = '0;
        found = 1'b0;
        for (int v = 0; v < VOICES; v++) begin
            if (!found) begin
                if (voice_len[v] == '0) begin
                    pick  = v;
                    found = 1'b1;
                end else if (voice_pos[v] > best) begin
                    best = voice_pos[v];
                    pick = v;
                end
            end
        end
        voice_base[pick] = clip_start[clip];
        voice_len[pick]  = clip_len[clip];
        voice_pos[pick]  = '0;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CLIPS; c++) begin
                clip_start[c] = '0;
                clip_len[c]   = '0;
            end
            for (int v = 0; v < VOICES; v++) begin
                voice_base[v] = '0;
                voice_len[v]  = '0;
                voice_pos[v]  = '0;
            end
            mix_volume = VOL_W'(VOLUME_RESET);
            mix_on     = 1'b0;
            mix_due.delete();
        end else begin
            // score the result before queueing one from a tick taken at this edge
            if (i_strobe) begin
                if (mix_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mixed sample %0d with no tick outstanding", i_mixed_sample);
                    end
                end else begin
                    want = mix_due.pop_front();
                    if (want !== i_mixed_sample) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mixed sample mismatch: expected %0d, got %0d",
                                     want, i_mixed_sample);
                        end
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_VOLUME:  mix_volume = i_cfg_data;
                    CFG_ENABLED: mix_on = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                case (t_opcode'(i_opcode))
                    OP_LOAD_SAMPLE: pcm_mem[i_address] = i_sample_data;
                    OP_LOAD_CLIP: begin
                        clip_start[i_clip_index] = i_address;
                        clip_len[i_clip_index]   = i_clip_length;
                    end
                    OP_PLAY: begin
                        if (mix_on) begin
                            start_voice(i_clip_index);
                        end
                    end
                    OP_TICK: begin
                        if (mix_on) begin
                            mix_due.push_back(mix_voices());
                        end
                    end
                    default: ;
                endcase
            end
        end
        o_err_count = mismatches;
        o_waiting   = mix_due.size();
    end

endmodule

// ===== verif/tb_pcm_voice_mixer.sv =====
`timescale 1ns / 1ps

module tb_pcm_voice_mixer;
    import pmx_pkg::*;

    localparam int RUN_ITEMS     = 1150;
    localparam int PHASES        = 8;
    localparam int STALL_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = VOICES + 8;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [1:0]             i_opcode = '0;
    logic [15:0]            i_address = '0;
    logic signed [15:0]     i_sample_data = '0;
    logic [3:0]             i_clip_index = '0;
    logic [16:0]            i_clip_length = '0;
    logic                   o_strobe;
    logic signed [15:0]     o_mixed_sample;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DAT_W-1:0]   i_cfg_data = '0;

    int mix_errors;
    int pending_mixes;
    int idle_pct = 0;
    int counted = 0;
    int idle_run = 0;
    bit mem_written [MEM_DEPTH];

    logic [7:0] phase_vol [PHASES] = '{8'd0, 8'd1, 8'd128, 8'd255, 8'd37, 8'd22, 8'd200, 8'd255};
    logic [7:0] phase_en [PHASES]  = '{8'h01, 8'h01, 8'hFE, 8'h81, 8'h01, 8'hFF, 8'h03, 8'h01};

    pcm_voice_mixer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_address      (i_address),
        .i_sample_data  (i_sample_data),
        .i_clip_index   (i_clip_index),
        .i_clip_length  (i_clip_length),
        .o_strobe       (o_strobe),
        .o_mixed_sample (o_mixed_sample),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    pmx_mix_checker chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_opcode       (i_opcode),
        .i_address      (i_address),
        .i_sample_data  (i_sample_data),
        .i_clip_index   (i_clip_index),
        .i_clip_length  (i_clip_length),
        .i_strobe       (o_strobe),
        .i_mixed_sample (o_mixed_sample),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_err_count    (mix_errors),
        .o_waiting      (pending_mixes)
    );

    always #5 i_clk = ~i_clk;

    // End the run once nothing has moved for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || (i_cfg_valid && o_cfg_ready) || o_strobe) begin
            idle_run = 0;
        end else begin
            idle_run++;
        end
        if (idle_run >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [15:0] pick_pcm();
        case ($urandom_range(7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_start();
        case ($urandom_range(9))
            0: return 16'hFFFF - 16'($urandom_range(7));
            1: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly short clips so voices free up; some long and overlong ones.
    function automatic logic [16:0] pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 8) return 17'd0;
        if (r < 38) return 17'($urandom_range(4, 1));
        if (r < 73) return 17'($urandom_range(64, 5));
        if (r < 83) return 17'($urandom_range(65536, 65));
        if (r < 88) return 17'h10000;
        return 17'($urandom_range(131071, 65537));
    endfunction

    task automatic send_item(t_opcode op, logic [15:0] addr, logic [15:0] data,
                             logic [3:0] clip, logic [16:0] len);
        counted++;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        i_opcode      <= op;
        i_address     <= addr;
        i_sample_data <= data;
        i_clip_index  <= clip;
        i_clip_length <= len;
        start         <= 1'b1;
        do @(posedge i_clk); while (busy);
        if (op == OP_LOAD_SAMPLE) begin
            mem_written[addr] = 1'b1;
        end
        @(negedge i_clk);
    endtask

    // Fill any word an active voice is about to read, then tick.
    task automatic tick_mixer();
        t_saddr rd_addr;
        if (chk.mix_on) begin
            for (int v = 0; v < VOICES; v++) begin
                rd_addr = chk.voice_base[v] + t_saddr'(chk.voice_pos[v]);
                if (chk.voice_len[v] != '0 && !mem_written[rd_addr]) begin
                    send_item(OP_LOAD_SAMPLE, rd_addr, pick_pcm(), 4'($urandom),
                              17'($urandom));
                end
            end
        end
        send_item(OP_TICK, 16'($urandom), 16'($urandom), 4'($urandom), 17'($urandom));
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        start       <= 1'b0;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Hold off until every tick has answered and the block has gone quiet.
    task automatic drain();
        start <= 1'b0;
        while (pending_mixes != 0 || busy) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        int       target;
        int       n;
        int       phase_idle;
        int       r;
        int       v;
        t_saddr   near_addr;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // writes to unused register slots must be dropped
        write_reg(CFG_SPARE_A, 8'($urandom));
        write_reg(CFG_SPARE_B, 8'($urandom));

        // still disabled after reset: tick and play do nothing
        tick_mixer();
        send_item(OP_PLAY, 16'hFFFF, 16'h8000, 4'd15, 17'h1FFFF);

        write_reg(CFG_VOLUME, 8'd255);
        write_reg(CFG_ENABLED, 8'h01);

        tick_mixer();
        send_item(OP_LOAD_SAMPLE, 16'hFFFF, 16'h7FFF, 4'd0, 17'd0);
        send_item(OP_LOAD_SAMPLE, 16'h0000, 16'h7FFF, 4'd0, 17'd0);
        send_item(OP_LOAD_SAMPLE, 16'h0001, 16'h8000, 4'd0, 17'd0);
        // clip crossing the top of sample memory, two voices clip high
        send_item(OP_LOAD_CLIP, 16'hFFFF, 16'h0000, 4'd0, 17'd2);
        send_item(OP_PLAY, 16'h0000, 16'h0000, 4'd0, 17'd0);
        send_item(OP_PLAY, 16'h0000, 16'h0000, 4'd0, 17'd0);
        tick_mixer();
        tick_mixer();
        send_item(OP_LOAD_CLIP, 16'h0001, 16'h0000, 4'd15, 17'd1);
        send_item(OP_PLAY, 16'h0000, 16'h0000, 4'd15, 17'd0);
        send_item(OP_PLAY, 16'h0000, 16'h0000, 4'd15, 17'd0);
        tick_mixer();
        // longest clip on every voice, then a zero-length clip steals one
        send_item(OP_LOAD_CLIP, 16'h7FFE, 16'h0000, 4'd4, 17'h1FFFF);
        repeat (VOICES) send_item(OP_PLAY, 16'h0000, 16'h0000, 4'd4, 17'd0);
        tick_mixer();
        send_item(OP_LOAD_CLIP, 16'hABCD, 16'h0000, 4'd3, 17'd0);
        send_item(OP_PLAY, 16'h0000, 16'h0000, 4'd3, 17'd0);
        tick_mixer();

        counted = 0;
        for (int p = 0; p < PHASES; p++) begin
            drain();
            write_reg(CFG_VOLUME, phase_vol[p]);
            write_reg(CFG_ENABLED, phase_en[p]);
            if (p % 2 == 1) begin
                write_reg((p % 4 == 1) ? CFG_SPARE_A : CFG_SPARE_B, 8'($urandom));
            end
            phase_idle = (p % 3 == 1) ? 64 : ((p % 3 == 2) ? 14 : 0);
            target = (RUN_ITEMS * (p + 1)) / PHASES;
            n = 0;
            while (counted < target) begin
                idle_pct = (n % 40 < 8) ? 0 : phase_idle;
                r = $urandom_range(99);
                if (r < 25) begin
                    // half the sample writes land just ahead of a playing voice
                    v = $urandom_range(VOICES - 1);
                    near_addr = chk.voice_base[v] + t_saddr'(chk.voice_pos[v])
                                + t_saddr'($urandom_range(3));
                    send_item(OP_LOAD_SAMPLE, $urandom_range(1) ? near_addr : 16'($urandom),
                              pick_pcm(), 4'($urandom), 17'($urandom));
                end else if (r < 40) begin
                    send_item(OP_LOAD_CLIP, pick_start(), 16'($urandom), 4'($urandom),
                              pick_len());
                end else if (r < 60) begin
                    send_item(OP_PLAY, 16'($urandom), 16'($urandom), 4'($urandom),
                              17'($urandom));
                end else begin
                    tick_mixer();
                end
                n++;
            end
        end

        idle_pct = 0;
        drain();
        if (mix_errors == 0 && pending_mixes == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/pmx_pkg.sv
rtl/pmx_scaler.sv
rtl/pcm_voice_mixer.sv
rtl/pmx_checker.sv
verif/pmx_mix_checker.sv
verif/tb_pcm_voice_mixer.sv
